[sv/eab_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler angle basis package
// Shared widths, defaults, pipeline depths and beat types of the block.
// ----------------------------------------------------------------------------
package eab_pkg;

  localparam int SINE_STEPS_DEF    = 1024;
  localparam int OUT_FRAC_BITS_DEF = 14;

  localparam int ANGLE_W = 16;
  localparam int COMP_W  = 16;

  localparam int TAYLOR_TERMS = 8;

  localparam int IDX_STAGES   = 5;
  localparam int SINE_STAGES  = 7 + 3 * TAYLOR_TERMS;
  localparam int MERGE_STAGES = 3;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_deg;
    logic signed [ANGLE_W-1:0] yaw_deg;
    logic signed [ANGLE_W-1:0] roll_deg;
  } angles_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] forward_x;
    logic signed [COMP_W-1:0] forward_y;
    logic signed [COMP_W-1:0] forward_z;
    logic signed [COMP_W-1:0] up_x;
    logic signed [COMP_W-1:0] up_y;
    logic signed [COMP_W-1:0] up_z;
    logic signed [COMP_W-1:0] right_x;
    logic signed [COMP_W-1:0] right_y;
    logic signed [COMP_W-1:0] right_z;
  } basis_t;

endpackage
`default_nettype wire

[sv/eab_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface eab_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/euler_angles_to_basis_vectors.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler angles to basis vectors
// Turns pitch, yaw and roll in 1/64-degree units into the forward, up and right unit
// vectors of the rotation, nine Q1.14 components per result beat.
//
// The angles channel takes one beat per cycle while the skid register is
// empty; each beat gives exactly one beat on the basis channel, in order. Six
// sine lanes (sine and cosine of each angle) run side by side and the merge
// stages form the products. The pipeline holds index reduction, sine
// evaluation (four phase stages, two radian stages, three per series term,
// one rounding stage), merging and the output register. Throughput is one
// beat per cycle while the skid register is empty.
// When the receiver stalls, the finished beat waits in the output register
// and one more lands in a skid register; while the skid register is full,
// angles.ready is low and the whole pipeline holds. Reset clears the valid
// bits of the pipeline, the output register and the skid register.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors #(
  parameter int SINE_STEPS    = eab_pkg::SINE_STEPS_DEF,
  parameter int OUT_FRAC_BITS = eab_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  eab_stream_if.sink   angles,
  eab_stream_if.source basis
);

  localparam int IW  = $clog2(SINE_STEPS);
  localparam int SW  = OUT_FRAC_BITS + 2;
  localparam int LAT = eab_pkg::IDX_STAGES + eab_pkg::SINE_STAGES + eab_pkg::MERGE_STAGES;

  logic                   en;
  logic [LAT-1:0]         vld;
  logic                   out_valid;
  logic                   skid_valid;
  eab_pkg::basis_t        out_data;
  eab_pkg::basis_t        skid_data;
  eab_pkg::basis_t        pipe_data;
  logic        [IW-1:0]   idx  [6];
  logic signed [SW-1:0]   trig [6];

  assign en           = !skid_valid;
  assign angles.ready = en;
  assign basis.valid  = out_valid;
  assign basis.data   = out_data;

  eab_angle_index #(.SINE_STEPS(SINE_STEPS)) u_pitch_idx (
    .clk     (clk),
    .en      (en),
    .angle   (angles.data.pitch_deg),
    .sin_idx (idx[0]),
    .cos_idx (idx[1])
  );

  eab_angle_index #(.SINE_STEPS(SINE_STEPS)) u_yaw_idx (
    .clk     (clk),
    .en      (en),
    .angle   (angles.data.yaw_deg),
    .sin_idx (idx[2]),
    .cos_idx (idx[3])
  );

  eab_angle_index #(.SINE_STEPS(SINE_STEPS)) u_roll_idx (
    .clk     (clk),
    .en      (en),
    .angle   (angles.data.roll_deg),
    .sin_idx (idx[4]),
    .cos_idx (idx[5])
  );

  for (genvar g = 0; g < 6; g++) begin : g_lane
    eab_sine_lane #(
      .SINE_STEPS    (SINE_STEPS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .idx   (idx[g]),
      .value (trig[g])
    );
  end

  eab_basis_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
    .clk    (clk),
    .en     (en),
    .sx     (trig[0]),
    .cx     (trig[1]),
    .sy     (trig[2]),
    .cy     (trig[3]),
    .sz     (trig[4]),
    .cz     (trig[5]),
    .result (pipe_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[LAT-2:0], angles.valid};
      end
      if (skid_valid) begin
        if (basis.ready) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (vld[LAT-1]) begin
        if (!out_valid || basis.ready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (basis.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (basis.ready) begin
        out_data <= skid_data;
      end
    end else if (vld[LAT-1]) begin
      if (!out_valid || basis.ready) begin
        out_data <= pipe_data;
      end else begin
        skid_data <= pipe_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid register holds a beat while the output register is empty.");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !basis.ready && vld[LAT-1]))
    else $error("Skid register filled without a stalled output beat.");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(vld))
    else $error("Pipeline advanced while the skid register was full.");

endmodule
`default_nettype wire

[sv/eab_angle_index.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Angle to table index
// Reduces one angle modulo a full turn and rounds it to the nearest sine
// table position; also gives the position a quarter turn ahead for cosine.
// ----------------------------------------------------------------------------
module eab_angle_index #(
  parameter int SINE_STEPS = eab_pkg::SINE_STEPS_DEF,
  localparam int IW = $clog2(SINE_STEPS)
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [eab_pkg::ANGLE_W-1:0] angle,
  output logic        [IW-1:0]               sin_idx,
  output logic        [IW-1:0]               cos_idx
);

  localparam int NW   = $clog2(SINE_STEPS + 1);
  localparam int NUMW = 15 + NW;
  localparam int HW   = NUMW - 9;
  localparam logic        [NW-1:0]   NC       = NW'(SINE_STEPS);
  localparam logic signed [16:0]     TURN     = 17'sd23040;
  localparam logic signed [16:0]     TWO_TURN = 17'sd46080;
  localparam logic        [NUMW-1:0] HALF     = NUMW'(11520);
  localparam logic        [5:0]      ODD_DIV  = 6'd45;
  localparam longint                 M45_L    = (longint'(1) << HW) / 45;
  localparam logic        [NW:0]     M45      = (NW + 1)'(M45_L);
  localparam logic        [IW:0]     NCI      = (IW + 1)'(SINE_STEPS);
  localparam logic        [IW:0]     QTRI     = (IW + 1)'(SINE_STEPS / 4);

  logic signed [16:0]      ax;
  logic        [14:0]      am_next;
  logic        [14:0]      am;
  logic        [NUMW-1:0]  prod;
  logic        [NUMW-1:0]  num;
  logic        [HW-1:0]    hn;
  logic        [HW+NW:0]   prod2;
  logic        [HW-1:0]    h;
  logic        [NW-1:0]    q0;
  logic        [HW-1:0]    qd;
  logic        [HW-1:0]    rem;
  logic        [NW-1:0]    qv;
  logic        [IW-1:0]    idx;
  logic        [IW:0]      csum;

  always_comb begin
    ax = 17'(angle);
    if (ax < -TURN) begin
      am_next = 15'(ax + TWO_TURN);
    end else if (ax < 0) begin
      am_next = 15'(ax + TURN);
    end else if (ax >= TURN) begin
      am_next = 15'(ax - TURN);
    end else begin
      am_next = 15'(ax);
    end
  end

  assign prod  = am * NC;
  assign hn    = num[NUMW-1:9];
  assign prod2 = hn * M45;
  assign qd    = q0 * ODD_DIV;
  assign rem   = h - qd;
  assign qv    = (rem >= HW'(ODD_DIV)) ? q0 + NW'(1) : q0;
  assign csum  = {1'b0, idx} + QTRI;

  always_ff @(posedge clk) begin
    if (en) begin
      am      <= am_next;
      num     <= prod + HALF;
      h       <= hn;
      q0      <= prod2[HW+NW-1:HW];
      idx     <= (qv == NC) ? '0 : IW'(qv);
      sin_idx <= idx;
      cos_idx <= (csum >= NCI) ? IW'(csum - NCI) : IW'(csum);
    end
  end

endmodule
`default_nettype wire

[sv/eab_taylor_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Taylor series step
// Forms the next series term as term * x^2 / ((2n)(2n+1)) in Q30 and adds
// it to the running sum with alternating sign, over three stages.
// ----------------------------------------------------------------------------
module eab_taylor_step #(
  parameter int N_TERM = 1
) (
  input  logic               clk,
  input  logic               en,
  input  logic        [30:0] term_in,
  input  logic        [31:0] x2_in,
  input  logic signed [33:0] sum_in,
  output logic        [30:0] term_out,
  output logic        [31:0] x2_out,
  output logic signed [33:0] sum_out
);

  localparam int              DIV = (2 * N_TERM) * (2 * N_TERM + 1);
  localparam int              DW  = $clog2(DIV + 1);
  localparam logic [DW-1:0]   DC  = DW'(DIV);
  localparam logic [30:0]     MC  = 31'((longint'(1) << 33) / DIV);
  localparam bit              ODD = (N_TERM % 2) == 1;

  logic        [62:0]    tp;
  logic        [32:0]    p;
  logic        [31:0]    x2a;
  logic signed [33:0]    suma;
  logic        [63:0]    pm;
  logic        [30:0]    q0;
  logic        [32:0]    pb;
  logic        [31:0]    x2b;
  logic signed [33:0]    sumb;
  logic        [30+DW:0] qd;
  logic        [33:0]    rem;
  logic        [30:0]    qv;
  logic signed [33:0]    qs;

  assign tp  = term_in * x2_in;
  assign pm  = p * MC;
  assign qd  = q0 * DC;
  assign rem = 34'(pb) - 34'(qd);
  assign qv  = (rem >= 34'(DIV)) ? q0 + 31'd1 : q0;
  assign qs  = $signed(34'(qv));

  always_ff @(posedge clk) begin
    if (en) begin
      p        <= tp[62:30];
      x2a      <= x2_in;
      suma     <= sum_in;
      q0       <= pm[63:33];
      pb       <= p;
      x2b      <= x2a;
      sumb     <= suma;
      term_out <= qv;
      x2_out   <= x2b;
      sum_out  <= ODD ? sumb - qs : sumb + qs;
    end
  end

endmodule
`default_nettype wire

[sv/eab_sine_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine lane
// Computes the sine table entry at one index: phase in Q32 turns, quadrant
// fold, radians in Q30, Taylor series to x^17, clamp, round and sign.
// ----------------------------------------------------------------------------
module eab_sine_lane #(
  parameter int SINE_STEPS    = eab_pkg::SINE_STEPS_DEF,
  parameter int OUT_FRAC_BITS = eab_pkg::OUT_FRAC_BITS_DEF,
  localparam int IW = $clog2(SINE_STEPS),
  localparam int SW = OUT_FRAC_BITS + 2
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic        [IW-1:0] idx,
  output logic signed [SW-1:0] value
);

  localparam longint          QT_L      = 64'sd4294967296 / SINE_STEPS;
  localparam longint          RT_L      = 64'sd4294967296 % SINE_STEPS;
  localparam int              QW        = $clog2(QT_L + 1);
  localparam int              NW        = $clog2(SINE_STEPS + 1);
  localparam logic [QW-1:0]   QT        = QW'(QT_L);
  localparam logic [NW-1:0]   RT        = NW'(RT_L);
  localparam logic [NW-1:0]   NC        = NW'(SINE_STEPS);
  localparam logic [30:0]     TWO_PI_Q28 = 31'd1686629713;
  localparam logic [30:0]     QUARTER   = 31'h4000_0000;
  localparam int              TERMS     = eab_pkg::TAYLOR_TERMS;
  localparam int              NEG_DEPTH = 2 + 3 * TERMS;
  localparam int              MW        = OUT_FRAC_BITS + 1;

  logic        [IW+QW-1:0]   kq_p;
  logic        [IW+NW-1:0]   kr_p;
  logic        [31:0]        kq;
  logic        [31:0]        kr;
  logic        [31+QW:0]     q0_p;
  logic        [QW-1:0]      q0;
  logic        [31:0]        kq2;
  logic        [31:0]        kr2;
  logic        [QW+NW-1:0]   qn_p;
  logic        [31:0]        rem;
  logic        [QW-1:0]      qv;
  logic        [31:0]        t;
  logic        [30:0]        r1;
  logic                      neg0;
  logic        [NEG_DEPTH-1:0] neg_line;
  logic        [61:0]        xp;
  logic        [30:0]        x;
  logic        [61:0]        xx;
  logic        [30:0]        term_c [TERMS+1];
  logic        [31:0]        x2_c   [TERMS+1];
  logic signed [33:0]        sum_c  [TERMS+1];
  logic signed [33:0]        sum_f;
  logic        [30:0]        clamped;
  logic        [MW-1:0]      mag;

  assign kq_p = idx * QT;
  assign kr_p = idx * RT;
  assign q0_p = kr * QT;
  assign qn_p = q0 * NC;
  assign rem  = kr2 - 32'(qn_p);
  assign qv   = (rem >= 32'(SINE_STEPS)) ? q0 + QW'(1) : q0;
  assign xp   = r1 * TWO_PI_Q28;
  assign xx   = x * x;

  always_ff @(posedge clk) begin
    if (en) begin
      kq        <= 32'(kq_p);
      kr        <= 32'(kr_p);
      q0        <= q0_p[31+QW:32];
      kq2       <= kq;
      kr2       <= kr;
      t         <= kq2 + 32'(qv);
      r1        <= t[30] ? QUARTER - {1'b0, t[29:0]} : {1'b0, t[29:0]};
      neg0      <= t[31];
      neg_line  <= {neg_line[NEG_DEPTH-2:0], neg0};
      x         <= xp[60:30];
      x2_c[0]   <= xx[61:30];
      term_c[0] <= x;
      sum_c[0]  <= $signed(34'(x));
    end
  end

  for (genvar i = 0; i < TERMS; i++) begin : g_step
    eab_taylor_step #(
      .N_TERM (i + 1)
    ) u_step (
      .clk      (clk),
      .en       (en),
      .term_in  (term_c[i]),
      .x2_in    (x2_c[i]),
      .sum_in   (sum_c[i]),
      .term_out (term_c[i+1]),
      .x2_out   (x2_c[i+1]),
      .sum_out  (sum_c[i+1])
    );
  end

  assign sum_f = sum_c[TERMS];

  always_comb begin
    if (sum_f[33]) begin
      clamped = '0;
    end else if (sum_f > 34'sd1073741824) begin
      clamped = QUARTER;
    end else begin
      clamped = sum_f[30:0];
    end
  end

  if (OUT_FRAC_BITS < 30) begin : g_round
    localparam logic [31:0] RND = 32'd1 << (29 - OUT_FRAC_BITS);
    assign mag = MW'((32'(clamped) + RND) >> (30 - OUT_FRAC_BITS));
  end else begin : g_exact
    assign mag = MW'(clamped);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= neg_line[NEG_DEPTH-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule
`default_nettype wire

[sv/eab_basis_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Basis merge
// Combines the six sine and cosine lanes into the nine rotation components
// with rounded products, sums and saturation to plus or minus one.
// ----------------------------------------------------------------------------
module eab_basis_merge #(
  parameter int OUT_FRAC_BITS = eab_pkg::OUT_FRAC_BITS_DEF,
  localparam int SW = OUT_FRAC_BITS + 2
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [SW-1:0]  sx,
  input  logic signed [SW-1:0]  cx,
  input  logic signed [SW-1:0]  sy,
  input  logic signed [SW-1:0]  cy,
  input  logic signed [SW-1:0]  sz,
  input  logic signed [SW-1:0]  cz,
  output eab_pkg::basis_t       result
);

  localparam int PW = 2 * SW;
  localparam int XW = (SW + 1 > eab_pkg::COMP_W) ? SW + 1 : eab_pkg::COMP_W;
  localparam logic signed [PW-1:0] RND = PW'(longint'(1) << (OUT_FRAC_BITS - 1));
  localparam logic signed [SW:0]   ONE = (SW + 1)'(longint'(1) << OUT_FRAC_BITS);

  function automatic logic signed [SW-1:0] fmul(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b + RND;
    return SW'(p >>> OUT_FRAC_BITS);
  endfunction

  function automatic logic signed [SW:0] wide(input logic signed [SW-1:0] a);
    return (SW + 1)'(a);
  endfunction

  function automatic logic signed [eab_pkg::COMP_W-1:0] emit(input logic signed [SW:0] v);
    logic signed [SW:0]   sat;
    logic signed [XW-1:0] ext;
    if (v > ONE) begin
      sat = ONE;
    end else if (v < -ONE) begin
      sat = -ONE;
    end else begin
      sat = v;
    end
    ext = XW'(sat);
    return ext[eab_pkg::COMP_W-1:0];
  endfunction

  logic signed [SW-1:0] cysx, sysx, sycz, sysz, cycx, cxsz, cxcz, cycz, cysz, sycx;
  logic signed [SW-1:0] sx1, sz1, cz1;
  logic signed [SW-1:0] cysx_sz, cysx_cz, sysx_sz, sysx_cz;
  logic signed [SW-1:0] sycz2, sysz2, cycx2, cxsz2, cxcz2, cycz2, cysz2, sycx2, sx2;

  always_ff @(posedge clk) begin
    if (en) begin
      cysx <= fmul(cy, sx);
      sysx <= fmul(sy, sx);
      sycz <= fmul(sy, cz);
      sysz <= fmul(sy, sz);
      cycx <= fmul(cy, cx);
      cxsz <= fmul(cx, sz);
      cxcz <= fmul(cx, cz);
      cycz <= fmul(cy, cz);
      cysz <= fmul(cy, sz);
      sycx <= fmul(sy, cx);
      sx1  <= sx;
      sz1  <= sz;
      cz1  <= cz;

      cysx_sz <= fmul(cysx, sz1);
      cysx_cz <= fmul(cysx, cz1);
      sysx_sz <= fmul(sysx, sz1);
      sysx_cz <= fmul(sysx, cz1);
      sycz2   <= sycz;
      sysz2   <= sysz;
      cycx2   <= cycx;
      cxsz2   <= cxsz;
      cxcz2   <= cxcz;
      cycz2   <= cycz;
      cysz2   <= cysz;
      sycx2   <= sycx;
      sx2     <= sx1;

      result.forward_x <= emit(wide(sycz2) + wide(cysx_sz));
      result.forward_y <= emit(wide(sysz2) - wide(cysx_cz));
      result.forward_z <= emit(wide(cycx2));
      result.up_x      <= emit(-wide(cxsz2));
      result.up_y      <= emit(wide(cxcz2));
      result.up_z      <= emit(wide(sx2));
      result.right_x   <= emit(wide(cycz2) - wide(sysx_sz));
      result.right_y   <= emit(wide(cysz2) + wide(sysx_cz));
      result.right_z   <= emit(-wide(sycx2));
    end
  end

endmodule
`default_nettype wire

[bench/euler_basis_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler angle basis checker
// Watches the angles and basis channels. For every accepted angle triple it
// computes the nine basis components from its own sine table and fixed-point
// products, and compares each basis beat, component by component, with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module euler_basis_checker #(
  parameter int SINE_STEPS    = eab_pkg::SINE_STEPS_DEF,
  parameter int OUT_FRAC_BITS = eab_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             angles_valid,
  input  logic             angles_ready,
  input  eab_pkg::angles_t angles_data,
  input  logic             basis_valid,
  input  logic             basis_ready,
  input  eab_pkg::basis_t  basis_data,
  output int               errors,
  output int               pending,
  output int               beats_checked
);

  localparam longint TURN_UNITS = 23040;
  localparam longint RAD_SCALE  = 1686629713;
  localparam int     QUARTER    = SINE_STEPS / 4;

  longint          sine_lut [SINE_STEPS];
  eab_pkg::basis_t expected_basis_q [$];

  function automatic longint quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int unsigned     n;
    x    = (r * RAD_SCALE) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
    return acc;
  endfunction

  function automatic longint sine_entry(longint unsigned k);
    longint unsigned t;
    longint unsigned r;
    int unsigned     quad;
    longint          s;
    t    = (k << 32) / longint'(SINE_STEPS);
    quad = int'((t >> 30) & 64'd3);
    r    = t & ((64'd1 << 30) - 64'd1);
    if (quad[0]) r = (64'd1 << 30) - r;
    s = quarter_sine(r);
    if (OUT_FRAC_BITS < 30) begin
      s = (s + (longint'(1) <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
    end
    return quad[1] ? -s : s;
  endfunction

  function automatic int unsigned angle_step(logic signed [eab_pkg::ANGLE_W-1:0] raw);
    longint a;
    a = raw;
    a = a % TURN_UNITS;
    if (a < 0) a = a + TURN_UNITS;
    return int'(((a * SINE_STEPS + TURN_UNITS / 2) / TURN_UNITS) % SINE_STEPS);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (longint'(1) <<< (OUT_FRAC_BITS - 1))) >>> OUT_FRAC_BITS;
  endfunction

  function automatic logic signed [eab_pkg::COMP_W-1:0] to_component(longint v);
    longint unit_val;
    unit_val = longint'(1) <<< OUT_FRAC_BITS;
    if (v > unit_val) v = unit_val;
    if (v < -unit_val) v = -unit_val;
    return v[eab_pkg::COMP_W-1:0];
  endfunction

  function automatic eab_pkg::basis_t predict_basis(eab_pkg::angles_t ang);
    int unsigned     ix, iy, iz;
    longint          sx, cx, sy, cy, sz, cz, cysx, sysx;
    eab_pkg::basis_t b;
    ix   = angle_step(ang.pitch_deg);
    iy   = angle_step(ang.yaw_deg);
    iz   = angle_step(ang.roll_deg);
    sx   = sine_lut[ix];
    cx   = sine_lut[(ix + QUARTER) % SINE_STEPS];
    sy   = sine_lut[iy];
    cy   = sine_lut[(iy + QUARTER) % SINE_STEPS];
    sz   = sine_lut[iz];
    cz   = sine_lut[(iz + QUARTER) % SINE_STEPS];
    cysx = qmul(cy, sx);
    sysx = qmul(sy, sx);
    b.forward_x = to_component(qmul(sy, cz) + qmul(cysx, sz));
    b.forward_y = to_component(qmul(sy, sz) - qmul(cysx, cz));
    b.forward_z = to_component(qmul(cy, cx));
    b.up_x      = to_component(-qmul(cx, sz));
    b.up_y      = to_component(qmul(cx, cz));
    b.up_z      = to_component(sx);
    b.right_x   = to_component(qmul(cy, cz) - qmul(sysx, sz));
    b.right_y   = to_component(qmul(cy, sz) + qmul(sysx, cz));
    b.right_z   = to_component(-qmul(sy, cx));
    return b;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_component(string name, logic signed [eab_pkg::COMP_W-1:0] got,
                                 logic signed [eab_pkg::COMP_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d %s got %0d expected %0d",
                                beats_checked, name, got, want));
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < SINE_STEPS; k++) sine_lut[k] = sine_entry(longint'(k));
  end

  always @(posedge clk) begin
    eab_pkg::basis_t want;
    if (rst) begin
      errors        = 0;
      pending       = 0;
      beats_checked = 0;
    end else begin
      if (angles_valid && angles_ready) begin
        expected_basis_q.push_back(predict_basis(angles_data));
      end
      if (basis_valid && basis_ready) begin
        if (expected_basis_q.size() == 0) begin
          report_mismatch("basis beat arrived with no angle triple outstanding");
        end else begin
          want = expected_basis_q.pop_front();
          check_component("forward_x", basis_data.forward_x, want.forward_x);
          check_component("forward_y", basis_data.forward_y, want.forward_y);
          check_component("forward_z", basis_data.forward_z, want.forward_z);
          check_component("up_x", basis_data.up_x, want.up_x);
          check_component("up_y", basis_data.up_y, want.up_y);
          check_component("up_z", basis_data.up_z, want.up_z);
          check_component("right_x", basis_data.right_x, want.right_x);
          check_component("right_y", basis_data.right_y, want.right_y);
          check_component("right_z", basis_data.right_z, want.right_z);
        end
        beats_checked++;
      end
      pending = expected_basis_q.size();
    end
  end

endmodule

[bench/euler_angles_to_basis_vectors_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler angles to basis vectors testbench
// Sends a directed set of angle triples (zero, right angles, full-scale codes,
// turn wrap and table rounding edges) followed by random triples, while both
// channels idle and stall at random. The checker predicts and compares; this
// module drives the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors_tb;

  localparam int N_DIRECTED  = 20;
  localparam int N_RANDOM    = 900;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 60;

  localparam int DIRECTED_SET [N_DIRECTED][3] = '{
    '{0, 0, 0},
    '{5760, 0, 0},
    '{0, 5760, 0},
    '{0, 0, 5760},
    '{11520, 11520, 11520},
    '{-5760, -5760, -5760},
    '{17280, -11520, 23040},
    '{32767, 32767, 32767},
    '{-32768, -32768, -32768},
    '{-1, 1, -1},
    '{2880, 2880, 2880},
    '{-2880, 2880, -2880},
    '{11, 12, 23029},
    '{23028, -11, -12},
    '{22, 23, -23040},
    '{32767, -32768, 0},
    '{-32768, 0, 32767},
    '{5760, 5760, 5760},
    '{-17280, 17280, -17280},
    '{1920, 3840, 960}
  };

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   beats_checked;
  int   cycle_count;
  int   longest_stall;
  int   drains;

  eab_stream_if #(.payload_t(eab_pkg::angles_t)) angles_ch ();
  eab_stream_if #(.payload_t(eab_pkg::basis_t))  basis_ch ();

  euler_angles_to_basis_vectors uut (
    .clk    (clk),
    .rst    (rst),
    .angles (angles_ch),
    .basis  (basis_ch)
  );

  euler_basis_checker basis_check (
    .clk           (clk),
    .rst           (rst),
    .angles_valid  (angles_ch.valid),
    .angles_ready  (angles_ch.ready),
    .angles_data   (angles_ch.data),
    .basis_valid   (basis_ch.valid),
    .basis_ready   (basis_ch.ready),
    .basis_data    (basis_ch.data),
    .errors        (errors),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d basis beats outstanding",
               cycle_count, pending);
      $display("euler_angles_to_basis_vectors_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int hold_left;
    int run_len;
    bit open;
    int pick;
    hold_left     = 0;
    run_len       = 0;
    open          = 1'b0;
    longest_stall = 0;
    basis_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          open      = 1'b1;
          hold_left = $urandom_range(1, 8);
        end else if (pick < 85) begin
          open      = 1'b0;
          hold_left = $urandom_range(1, 3);
        end else if (pick < 95) begin
          open      = 1'b1;
          hold_left = $urandom_range(30, 120);
        end else begin
          open      = 1'b0;
          hold_left = $urandom_range(20, 60);
        end
      end
      hold_left--;
      run_len = open ? 0 : run_len + 1;
      if (run_len > longest_stall) longest_stall = run_len;
      basis_ch.ready <= rst ? 1'b0 : open;
    end
  end

  function automatic logic signed [eab_pkg::ANGLE_W-1:0] random_angle();
    int pick;
    int j;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      v = $urandom_range(0, 65535);
    end else if (pick < 80) begin
      v = (int'($urandom_range(0, 10)) - 5) * 5760 + int'($urandom_range(0, 6)) - 3;
    end else if (pick < 95) begin
      j = $urandom_range(0, 1023);
      v = ((2 * j + 1) * 23040) / 2048 + int'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) v = v - 23040;
    end else begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return v[eab_pkg::ANGLE_W-1:0];
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_angles(input eab_pkg::angles_t triple);
    angles_ch.data  <= triple;
    angles_ch.valid <= 1'b1;
    do @(posedge clk); while (!(angles_ch.valid && angles_ch.ready));
    @(negedge clk);
  endtask

  initial begin
    eab_pkg::angles_t triple;
    int               idx;
    int               gap;
    bit               drain;
    drains      = 0;
    rst             <= 1'b1;
    angles_ch.valid <= 1'b0;
    angles_ch.data  <= '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (idx = 0; idx < N_DIRECTED + N_RANDOM; idx++) begin
      if (idx < N_DIRECTED) begin
        triple.pitch_deg = eab_pkg::ANGLE_W'(DIRECTED_SET[idx][0]);
        triple.yaw_deg   = eab_pkg::ANGLE_W'(DIRECTED_SET[idx][1]);
        triple.roll_deg  = eab_pkg::ANGLE_W'(DIRECTED_SET[idx][2]);
      end else begin
        triple.pitch_deg = random_angle();
        triple.yaw_deg   = random_angle();
        triple.roll_deg  = random_angle();
      end
      send_angles(triple);
      gap   = (idx % 150 < 30) ? 0 : pick_gap();
      drain = (idx == N_DIRECTED - 1) || (idx == 400) || (idx == 700);
      if (gap != 0 || drain) begin
        angles_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
        if (drain) begin
          while (pending != 0) @(negedge clk);
          drains++;
        end
      end
    end
    angles_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d angle triples (%0d directed), checked %0d basis beats",
             N_DIRECTED + N_RANDOM, N_DIRECTED, beats_checked);
    $display("receiver stalls up to %0d cycles, pipeline drained %0d times, %0d mismatches",
             longest_stall, drains, errors);
    if (errors == 0 && pending == 0) begin
      $display("euler_angles_to_basis_vectors_tb: done, clean");
    end else begin
      $display("euler_angles_to_basis_vectors_tb: done, errors");
    end
    $finish;
  end

endmodule
